@@ sv/bif_pkg.sv @@
// ----------------------------------------------------------------------------
// bif_pkg
// shared types and character codes for the brace indent formatter
// ----------------------------------------------------------------------------
package bif_pkg;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [7:0] CSD_RESET = 8'd2;

    // job queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // one formatted source byte: up to three results
    typedef struct packed {
        logic [7:0] c;          // the byte itself
        logic [1:0] n;          // number of results, 1 to 3
        logic [2:0] brk;        // slot is a line break
        logic       sp;         // second slot is an added space
        logic [7:0] ind;        // indent carried by the breaks
        logic       run_last;   // last job of its request
        logic       stream_end; // last job of the text
    } t_job;

    typedef struct packed {
        logic v0;
        logic v1;
        t_job d0;
        t_job d1;
    } t_qpush;

    typedef struct packed {
        logic valid;
        logic room;             // at least two free entries
        t_job job;
    } t_qstat;

endpackage

@@ sv/brace_indent_formatter_core.sv @@
// ----------------------------------------------------------------------------
// brace_indent_formatter_core
// re-emits source text as bytes and indented line breaks
// ----------------------------------------------------------------------------
// Each source byte request on the slave stream is turned into a job by the
// front end, which holds one byte back and tracks quoting and brace depth;
// a four-entry job queue feeds the back end, which produces one result per
// clock into the output register unless the output stalls. A byte giving
// one result is taken every cycle unless the queue or output stalls; a byte
// giving more (at most six for the final byte) holds the back end until all
// are issued, and input stalls once fewer than two queue entries are free.
// The comma spacing depth is written on the cfg channel, which is always
// ready and is meant to be written only while the block is idle.
module brace_indent_formatter_core #(
    parameter int MAX_INDENT = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte, indent_units
    output logic [1:0]  m_axis_tuser,   // kind, stream_end
    output logic        m_axis_tlast    // run_last
);
    import bif_pkg::*;

    t_qpush     push;
    t_qstat     qstat;
    logic       pop;
    logic       kind;
    logic [7:0] obyte;
    logic [7:0] oind;
    logic       rl;
    logic       se;

    assign o_cfg_ready = 1'b1;

    bif_front #(
        .MAX_INDENT (MAX_INDENT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_ready     (s_axis_tready),
        .i_qstat     (qstat),
        .o_push      (push)
    );

    bif_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_stat  (qstat)
    );

    bif_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_qstat      (qstat),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_kind       (kind),
        .o_byte       (obyte),
        .o_ind        (oind),
        .o_run_last   (rl),
        .o_stream_end (se)
    );

    assign m_axis_tdata = {oind, obyte};
    assign m_axis_tuser = {se, kind};
    assign m_axis_tlast = rl;

endmodule

@@ sv/bif_front.sv @@
// ----------------------------------------------------------------------------
// bif_front
// holds one byte back, tracks quotes and brace depth, and turns each
// formatted byte into a job for the queue
// ----------------------------------------------------------------------------
module bif_front #(
    parameter int MAX_INDENT = 255
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output logic            o_ready,
    input  bif_pkg::t_qstat i_qstat,
    output bif_pkg::t_qpush o_push
);
    import bif_pkg::*;

    localparam int DW = $clog2(MAX_INDENT + 1);

    typedef struct packed {
        logic          in_q;
        logic [7:0]    qb;
        logic          esc;
        logic [DW-1:0] depth;
    } t_fst;

    typedef struct packed {
        t_fst st;
        t_job job;
    } t_fres;

    function automatic t_fres fmt(input logic [7:0] c, input logic [7:0] nx,
                                  input t_fst s, input logic [7:0] csd);
        t_fres         r;
        logic [DW-1:0] d;
        r         = '0;
        r.st      = s;
        r.job.c   = c;
        r.job.n   = 2'd1;
        d         = s.depth;
        if (s.in_q) begin
            if (s.esc) begin
                r.st.esc = 1'b0;
            end else if (c == CH_BSLASH) begin
                r.st.esc = 1'b1;
            end else if (c == s.qb) begin
                r.st.in_q = 1'b0;
            end
        end else if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BTICK) begin
            r.st.in_q = 1'b1;
            r.st.qb   = c;
        end else if (c == CH_LBRACE) begin
            if (32'(d) < 32'(MAX_INDENT)) d = d + DW'(1);
            r.job.n   = 2'd2;
            r.job.brk = 3'b010;
        end else if (c == CH_RBRACE) begin
            if (d != '0) d = d - DW'(1);
            r.job.brk = 3'b101;
            if (nx == CH_COMMA || nx == CH_SEMI || nx == CH_RPAREN ||
                nx == CH_RBRACE || nx == CH_NUL) begin
                r.job.n = 2'd2;
            end else begin
                r.job.n = 2'd3;
            end
        end else if (c == CH_SEMI) begin
            r.job.brk = 3'b010;
            if (nx == CH_RBRACE || nx == CH_NUL || nx == CH_NL) begin
                r.job.n = 2'd1;
            end else begin
                r.job.n = 2'd2;
            end
        end else if (c == CH_COMMA && 32'(d) <= 32'(csd) &&
                     nx != CH_SPACE && nx != CH_NL) begin
            r.job.n  = 2'd2;
            r.job.sp = 1'b1;
        end
        r.st.depth = d;
        r.job.ind  = (32'(d) > 32'd255) ? 8'hFF : 8'(d);
        return r;
    endfunction

    logic [7:0] r_csd;
    logic [7:0] r_held;
    logic       r_held_v;
    t_fst       r_st;

    t_fres fa;
    t_fres fb;
    t_fst  st_a;
    logic  acc;

    assign o_ready = i_qstat.room;
    assign acc     = i_valid && i_qstat.room;

    always_comb begin
        fa   = fmt(r_held, i_byte, r_st, r_csd);
        st_a = r_held_v ? fa.st : r_st;
        fb   = fmt(i_byte, CH_NUL, st_a, r_csd);
        fa.job.run_last   = !i_last;
        fa.job.stream_end = 1'b0;
        fb.job.run_last   = 1'b1;
        fb.job.stream_end = 1'b1;
    end

    always_comb begin
        o_push = '0;
        if (r_held_v) begin
            o_push.v0 = acc;
            o_push.d0 = fa.job;
            o_push.v1 = acc && i_last;
            o_push.d1 = fb.job;
        end else begin
            o_push.v0 = acc && i_last;
            o_push.d0 = fb.job;
            o_push.d1 = fb.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_csd    <= CSD_RESET;
            r_held   <= '0;
            r_held_v <= 1'b0;
            r_st     <= '0;
        end else begin
            if (i_cfg_valid) r_csd <= i_cfg_data;
            if (acc) begin
                if (i_last) begin
                    r_held   <= '0;
                    r_held_v <= 1'b0;
                    r_st     <= '0;
                end else begin
                    r_held   <= i_byte;
                    r_held_v <= 1'b1;
                    r_st     <= st_a;
                end
            end
        end
    end

endmodule

@@ sv/bif_queue.sv @@
// ----------------------------------------------------------------------------
// bif_queue
// short job queue between front and back, two writes and one read a cycle
// ----------------------------------------------------------------------------
module bif_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bif_pkg::t_qpush i_push,
    input  logic            i_pop,
    output bif_pkg::t_qstat o_stat
);
    import bif_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;
    logic [QAW:0]   n_cnt;
    logic           pop;

    assign pop = i_pop && (r_cnt != '0);

    always_comb begin
        n_cnt = r_cnt + (QAW+1)'(i_push.v0) + (QAW+1)'(i_push.v1) - (QAW+1)'(pop);
    end

    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.room  = (r_cnt <= (QAW+1)'(QDEPTH - 2));
    assign o_stat.job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.v0) r_mem[r_wr] <= i_push.d0;
        if (i_push.v1) r_mem[r_wr + QAW'(1)] <= i_push.d1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QAW'(i_push.v0) + QAW'(i_push.v1);
            if (pop) r_rd <= r_rd + QAW'(1);
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.v0 || i_push.v1) |-> (r_cnt <= (QAW+1)'(QDEPTH - 2)))
        else $error("job queue written without room");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v1 |-> i_push.v0)
        else $error("second job pushed without the first");

endmodule

@@ sv/bif_back.sv @@
// ----------------------------------------------------------------------------
// bif_back
// expands the head job into its results, one a cycle unless the output stalls, into the output register
// ----------------------------------------------------------------------------
module bif_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bif_pkg::t_qstat i_qstat,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_kind,
    output logic [7:0]      o_byte,
    output logic [7:0]      o_ind,
    output logic            o_run_last,
    output logic            o_stream_end
);
    import bif_pkg::*;

    logic [1:0] r_idx;
    logic       r_ov;
    logic       r_kind;
    logic [7:0] r_byte;
    logic [7:0] r_ind;
    logic       r_rl;
    logic       r_se;

    logic       load;
    logic       slot_last;
    logic       brk;
    logic [7:0] sbyte;
    t_job       hj;

    assign hj        = i_qstat.job;
    assign load      = i_qstat.valid && (!r_ov || i_ready);
    assign slot_last = (r_idx == hj.n - 2'd1);
    assign brk       = hj.brk[r_idx];
    assign o_pop     = load && slot_last;

    always_comb begin
        if (brk) begin
            sbyte = '0;
        end else if (r_idx == 2'd1 && hj.sp) begin
            sbyte = CH_SPACE;
        end else begin
            sbyte = hj.c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= brk;
            r_byte <= sbyte;
            r_ind  <= brk ? hj.ind : 8'd0;
            r_rl   <= slot_last && hj.run_last;
            r_se   <= slot_last && hj.stream_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (load) begin
                r_ov  <= 1'b1;
                r_idx <= slot_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid      = r_ov;
    assign o_kind       = r_kind;
    assign o_byte       = r_byte;
    assign o_ind        = r_ind;
    assign o_run_last   = r_rl;
    assign o_stream_end = r_se;

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_qstat.valid |-> (hj.n != 2'd0 && r_idx < hj.n))
        else $error("result slot beyond job length");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_se) |-> r_rl)
        else $error("end of text on a result that does not close its request");

endmodule
